// ===== src/assert_macros.svh =====
// assertion helpers shared by the rc4 engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on the rising edge, off during reset
`define RC4_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication
`define RC4_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RC4_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rc4_pkg.sv =====
package rc4_pkg;

  // action codes
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_SCHED = 2'd1;
  localparam logic [1:0] ACT_CRYPT = 2'd2;

  localparam logic [8:0] KEY_LEN_RESET = 9'd16;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_value;
    logic [7:0] key_position;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
  } out_item_t;

  typedef logic [8:0] cfg_item_t;

  // microprogram steps
  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_K0,
    S_K1,
    S_K2,
    S_K3,
    S_K4,
    S_KEND,
    S_C0,
    S_C1,
    S_C2,
    S_C3
  } step_e;

  typedef enum logic [2:0] {
    RA_II,
    RA_JJ,
    RA_INEXT,
    RA_JNEXT,
    RA_SUM,
    RA_TQ
  } ra_sel_e;

  typedef enum logic {
    WA_II,
    WA_JJ
  } wa_sel_e;

  typedef enum logic [1:0] {
    WD_II,
    WD_RDATA,
    WD_AQ
  } wd_sel_e;

  typedef enum logic {
    II_HOLD,
    II_INC
  } ii_op_e;

  typedef enum logic [1:0] {
    JJ_HOLD,
    JJ_CLEAR,
    JJ_KSA,
    JJ_PRGA
  } jj_op_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_DISPATCH,
    J_II_LAST,
    J_OUT_FREE,
    J_ALWAYS
  } jmp_e;

  typedef struct packed {
    ra_sel_e ra_sel;
    logic    we;
    wa_sel_e wa_sel;
    wd_sel_e wd_sel;
    ii_op_e  ii_op;
    jj_op_e  jj_op;
    logic    kidx_step;
    logic    a_ld;
    logic    b_ld;
    logic    t_ld;
    logic    out_ld;
    jmp_e    jmp;
    step_e   target;
  } ctrl_t;

  // control store
  function automatic ctrl_t ucode(step_e pc);
    ctrl_t cw;
    cw = '{ra_sel: RA_TQ, we: 1'b0, wa_sel: WA_II, wd_sel: WD_RDATA, ii_op: II_HOLD,
           jj_op: JJ_HOLD, kidx_step: 1'b0, a_ld: 1'b0, b_ld: 1'b0, t_ld: 1'b0,
           out_ld: 1'b0, jmp: J_NEXT, target: S_IDLE};
    case (pc)
      S_IDLE: begin
        cw.jmp = J_DISPATCH;
      end
      S_INIT: begin
        cw.we = 1'b1; cw.wa_sel = WA_II; cw.wd_sel = WD_II; cw.ii_op = II_INC;
        cw.jmp = J_II_LAST; cw.target = S_INIT;
      end
      S_K0: begin
        cw.ra_sel = RA_II;
      end
      S_K1: begin
        cw.a_ld = 1'b1; cw.jj_op = JJ_KSA;
      end
      S_K2: begin
        cw.ra_sel = RA_JJ;
      end
      S_K3: begin
        cw.we = 1'b1; cw.wa_sel = WA_II; cw.wd_sel = WD_RDATA;
      end
      S_K4: begin
        cw.we = 1'b1; cw.wa_sel = WA_JJ; cw.wd_sel = WD_AQ; cw.ii_op = II_INC;
        cw.kidx_step = 1'b1; cw.jmp = J_II_LAST; cw.target = S_K0;
      end
      S_KEND: begin
        cw.jj_op = JJ_CLEAR; cw.jmp = J_ALWAYS; cw.target = S_IDLE;
      end
      S_C0: begin
        cw.ra_sel = RA_INEXT; cw.ii_op = II_INC;
      end
      S_C1: begin
        cw.a_ld = 1'b1; cw.ra_sel = RA_JNEXT; cw.jj_op = JJ_PRGA;
      end
      S_C2: begin
        cw.b_ld = 1'b1; cw.we = 1'b1; cw.wa_sel = WA_II; cw.wd_sel = WD_RDATA;
        cw.ra_sel = RA_SUM; cw.t_ld = 1'b1;
      end
      S_C3: begin
        cw.we = 1'b1; cw.wa_sel = WA_JJ; cw.wd_sel = WD_AQ; cw.ra_sel = RA_TQ;
        cw.out_ld = 1'b1; cw.jmp = J_OUT_FREE; cw.target = S_IDLE;
      end
      default: begin
        cw.jmp = J_ALWAYS; cw.target = S_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== src/rc4_stream_if.sv =====
interface rc4_stream_if #(
  parameter type T = logic [7:0]
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rc4_stream_cipher_top.sv =====
// channel | dir | payload                               | transfer when
// in_i    | in  | action, byte_value, key_position      | valid & ready
// out_o   | out | out_byte (crypt only)                 | valid & ready
// cfg_i   | in  | key_length, 9 bits                    | valid & ready (ready tied high)
//
// load key byte: stored as it is taken; schedule: accept, identity fill, swap steps K0..K4 per entry, KEND
// crypt: accept, then steps C0..C3; the steps follow from the single registered read port of the ram
// reset clears the step counter, indices and the result slot and sets key_length to 16, no ram sweep
// the permutation is undefined until a schedule has run
// a crypt waits in its last step while the result slot still holds an untaken byte
// a new item is taken while a finished result waits at the output
`include "assert_macros.svh"

module rc4_stream_cipher_top #(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rc4_stream_if.sink   in_i,
  rc4_stream_if.source out_o,
  rc4_stream_if.sink   cfg_i
);

  localparam int unsigned KW      = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [8:0]  MAX_LEN = 9'(MAX_KEY_BYTES);

  // sequencer state
  rc4_pkg::step_e pc_q, pc_d;
  rc4_pkg::ctrl_t cw;

  // datapath registers
  logic [7:0]    ii_q, ii_d;
  logic [7:0]    jj_q, jj_d;
  logic [KW-1:0] kidx_q, kidx_d;
  logic [8:0]    key_len_q;
  logic [7:0]    a_q, b_q, t_q, byte_q;
  logic          out_valid_q;
  logic [7:0]    out_byte_q;

  // memories
  logic [7:0] perm_mem [256];
  logic [7:0] key_mem  [MAX_KEY_BYTES];
  logic [7:0] perm_rd_q;
  logic [7:0] key_rd_q;

  logic       in_xfer, out_free, start_sched, key_we;
  logic [7:0] perm_ra, perm_wa, perm_wd, sum, ks;
  logic [8:0] eff_len, len_m1;

  assign in_i.ready  = (pc_q == rc4_pkg::S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign start_sched = in_xfer && (in_i.data.action == rc4_pkg::ACT_SCHED);
  assign key_we      = in_xfer && (in_i.data.action == rc4_pkg::ACT_LOAD)
                       && ({1'b0, in_i.data.key_position} < MAX_LEN);

  assign out_o.valid         = out_valid_q;
  assign out_o.data.out_byte = out_byte_q;

  // key length clamped into 1..MAX_KEY_BYTES
  assign eff_len = (key_len_q == 9'd0) ? 9'd1 : ((key_len_q > MAX_LEN) ? MAX_LEN : key_len_q);
  assign len_m1  = eff_len - 9'd1;

  // control word for this step
  always_comb begin
    cw = rc4_pkg::ucode(pc_q);
  end

  // next step
  always_comb begin
    pc_d = pc_q;
    case (cw.jmp)
      rc4_pkg::J_NEXT:     pc_d = rc4_pkg::step_e'(4'(pc_q) + 4'd1);
      rc4_pkg::J_DISPATCH: begin
        if (in_xfer) begin
          case (in_i.data.action)
            rc4_pkg::ACT_SCHED: pc_d = rc4_pkg::S_INIT;
            rc4_pkg::ACT_CRYPT: pc_d = rc4_pkg::S_C0;
            default:            pc_d = rc4_pkg::S_IDLE;
          endcase
        end
      end
      rc4_pkg::J_II_LAST:  begin
        pc_d = (ii_q != 8'hff) ? cw.target : rc4_pkg::step_e'(4'(pc_q) + 4'd1);
      end
      rc4_pkg::J_OUT_FREE: pc_d = out_free ? cw.target : pc_q;
      rc4_pkg::J_ALWAYS:   pc_d = cw.target;
      default:             pc_d = rc4_pkg::S_IDLE;
    endcase
  end

  // datapath selects
  assign sum = a_q + perm_rd_q;

  always_comb begin
    case (cw.ra_sel)
      rc4_pkg::RA_II:    perm_ra = ii_q;
      rc4_pkg::RA_JJ:    perm_ra = jj_q;
      rc4_pkg::RA_INEXT: perm_ra = ii_q + 8'd1;
      rc4_pkg::RA_JNEXT: perm_ra = jj_q + perm_rd_q;
      rc4_pkg::RA_SUM:   perm_ra = sum;
      default:           perm_ra = t_q;
    endcase
    perm_wa = (cw.wa_sel == rc4_pkg::WA_JJ) ? jj_q : ii_q;
    case (cw.wd_sel)
      rc4_pkg::WD_II:    perm_wd = ii_q;
      rc4_pkg::WD_AQ:    perm_wd = a_q;
      default:           perm_wd = perm_rd_q;
    endcase
  end

  // index updates
  always_comb begin
    ii_d = (cw.ii_op == rc4_pkg::II_INC) ? ii_q + 8'd1 : ii_q;
    case (cw.jj_op)
      rc4_pkg::JJ_CLEAR: jj_d = 8'd0;
      rc4_pkg::JJ_KSA:   jj_d = jj_q + perm_rd_q + key_rd_q;
      rc4_pkg::JJ_PRGA:  jj_d = jj_q + perm_rd_q;
      default:           jj_d = jj_q;
    endcase
    kidx_d = kidx_q;
    if (cw.kidx_step) begin
      kidx_d = (9'(kidx_q) == len_m1) ? '0 : kidx_q + KW'(1);
    end
    if (start_sched) begin
      ii_d   = 8'd0;
      jj_d   = 8'd0;
      kidx_d = '0;
    end
  end

  // keystream byte; the swapped entries are taken from registers, not the ram
  assign ks = (t_q == jj_q) ? a_q : ((t_q == ii_q) ? b_q : perm_rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= rc4_pkg::S_IDLE;
      ii_q        <= 8'd0;
      jj_q        <= 8'd0;
      kidx_q      <= '0;
      key_len_q   <= rc4_pkg::KEY_LEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      ii_q   <= ii_d;
      jj_q   <= jj_d;
      kidx_q <= kidx_d;
      if (cfg_i.valid) begin
        key_len_q <= cfg_i.data;
      end
      if (cw.out_ld && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= in_i.data.byte_value;
    end
    if (cw.a_ld) begin
      a_q <= perm_rd_q;
    end
    if (cw.b_ld) begin
      b_q <= perm_rd_q;
    end
    if (cw.t_ld) begin
      t_q <= sum;
    end
    if (cw.out_ld && out_free) begin
      out_byte_q <= byte_q ^ ks;
    end
  end

  // permutation ram, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cw.we) begin
      perm_mem[perm_wa] <= perm_wd;
    end
    perm_rd_q <= perm_mem[perm_ra];
  end

  // key store
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[in_i.data.key_position[KW-1:0]] <= in_i.data.byte_value;
    end
    key_rd_q <= key_mem[kidx_q];
  end

  `RC4_ASSERT_IMP(a_out_from_crypt, clk_i, rst_ni, $rose(out_valid_q), $past(pc_q) == rc4_pkg::S_C3, "result raised outside the last crypt step")
  `RC4_ASSERT_NXT(a_sched_clears, clk_i, rst_ni, pc_q == rc4_pkg::S_KEND, (ii_q == 8'd0) && (jj_q == 8'd0), "indices not cleared after schedule")
  `RC4_ASSERT_IMP(a_kidx_range, clk_i, rst_ni, pc_q == rc4_pkg::S_K1, 9'(kidx_q) < eff_len, "key index beyond key length")
  `RC4_ASSERT_IMP(a_no_idle_write, clk_i, rst_ni, cw.we, pc_q != rc4_pkg::S_IDLE, "permutation written while idle")

endmodule

// ===== dv/rc4_stream_cipher_top_tb.sv =====
module rc4_stream_cipher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // action 3 has no meaning in the engine, it must be swallowed silently
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam int unsigned KEY_SLOTS = 256;
  // longer than a full schedule lasts, so anything idle-sensitive waits it out
  localparam int unsigned SETTLE_CYCLES = 1600;
  // long receiver hold-off so the result slot and the input both back up,
  // counted from the first result left waiting
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AFTER_RESULTS = 120;
  localparam int unsigned PHASE_ITEMS = 44;
  localparam int unsigned REPORT_LIMIT = 10;

  // key bytes for the directed part, extremes first
  localparam bit [7:0] OPENING_KEY [16] = '{
    8'h00, 8'hff, 8'h01, 8'h80, 8'haa, 8'h55, 8'h7f, 8'hfe,
    8'h10, 8'h0f, 8'hc3, 8'h3c, 8'h99, 8'h66, 8'he7, 8'h18
  };

  // shadow copy of the engine: key store, permutation, indices and key length,
  // plus the bytes still owed on the output in transfer order
  class keystream_shadow;
    bit [7:0]           sbox [KEY_SLOTS];
    bit [7:0]           key_bytes [KEY_SLOTS];
    bit [7:0]           idx_i;
    bit [7:0]           idx_j;
    rc4_pkg::cfg_item_t key_len;
    bit [7:0]           pending_bytes [$];
    int unsigned        fail_count;

    function new();
      foreach (sbox[n]) begin
        sbox[n] = '0;
        key_bytes[n] = '0;
      end
      idx_i = '0;
      idx_j = '0;
      key_len = rc4_pkg::KEY_LEN_RESET;
      fail_count = 0;
    endfunction

    function void set_key_length(rc4_pkg::cfg_item_t v);
      key_len = v;
    endfunction

    function void swap_entries(bit [7:0] a, bit [7:0] b);
      bit [7:0] t;
      t = sbox[a];
      sbox[a] = sbox[b];
      sbox[b] = t;
    endfunction

    // identity fill then 256 swap steps, key used cyclically
    function void run_key_schedule();
      int unsigned len;
      bit [7:0]    j;
      len = key_len;
      if (len < 1) len = 1;
      if (len > KEY_SLOTS) len = KEY_SLOTS;
      for (int k = 0; k < KEY_SLOTS; k++) sbox[k] = 8'(k);
      j = '0;
      for (int k = 0; k < KEY_SLOTS; k++) begin
        j = j + sbox[k] + key_bytes[k % len];
        swap_entries(8'(k), j);
      end
      idx_i = '0;
      idx_j = '0;
    endfunction

    function bit [7:0] crypt_byte(bit [7:0] data);
      bit [7:0] i;
      bit [7:0] j;
      bit [7:0] sum;
      i = idx_i + 8'd1;
      j = idx_j + sbox[i];
      swap_entries(i, j);
      sum = sbox[i] + sbox[j];
      idx_i = i;
      idx_j = j;
      return data ^ sbox[sum];
    endfunction

    function void take_item(rc4_pkg::in_item_t it);
      case (it.action)
        rc4_pkg::ACT_LOAD: key_bytes[it.key_position] = it.byte_value;
        rc4_pkg::ACT_SCHED: run_key_schedule();
        rc4_pkg::ACT_CRYPT: pending_bytes.push_back(crypt_byte(it.byte_value));
        default: begin
        end
      endcase
    endfunction

    function void check_byte(logic [7:0] got);
      bit [7:0] want;
      if (pending_bytes.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: out_byte %02h arrived with no crypt outstanding", $realtime, got);
        return;
      end
      want = pending_bytes.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: out_byte mismatch, expected %02h got %02h", $realtime, want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  rc4_stream_if #(.T(rc4_pkg::in_item_t))  in_if ();
  rc4_stream_if #(.T(rc4_pkg::out_item_t)) out_if ();
  rc4_stream_if #(.T(rc4_pkg::cfg_item_t)) cfg_if ();

  rc4_stream_cipher_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  keystream_shadow shadow;
  int unsigned     results_taken = 0;

  // stimulus-side bookkeeping: which key slots hold a value and the key
  // length the engine will really use
  bit [KEY_SLOTS-1:0] key_written;
  int unsigned        cur_len;

  // mostly back-to-back, some short gaps, the odd long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int unsigned eff_len(rc4_pkg::cfg_item_t v);
    // zero acts as one, anything past the store size is clamped
    if (v == 0) return 1;
    if (v > KEY_SLOTS) return KEY_SLOTS;
    return v;
  endfunction

  function automatic rc4_pkg::in_item_t make_item(logic [1:0] act, logic [7:0] val,
                                                  logic [7:0] pos);
    rc4_pkg::in_item_t it;
    it.action = act;
    it.byte_value = val;
    it.key_position = pos;
    return it;
  endfunction

  // offers one item and returns at the edge where it transfers; valid is left
  // high so a following item can go out without a bubble
  task automatic send_item(rc4_pkg::in_item_t it, bit burst);
    int unsigned gap;
    gap = burst ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    if (it.action == rc4_pkg::ACT_LOAD) key_written[it.key_position] = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // drop valid, let every owed byte come out, then give a running schedule
  // time to finish so the engine is truly idle
  task automatic settle();
    in_if.valid <= 1'b0;
    while (shadow.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_key_length(rc4_pkg::cfg_item_t v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    cur_len = eff_len(v);
  endtask

  // one key-length setting: fill any key slot the schedule would read that
  // has never been written, schedule, then a random mix dominated by crypts
  task automatic run_phase(int unsigned n_items);
    int unsigned done;
    int unsigned roll;
    bit          burst;
    logic [7:0]  pos;
    burst = ($urandom_range(3, 0) == 0);
    for (int p = 0; p < cur_len; p++)
      if (!key_written[p]) send_item(make_item(rc4_pkg::ACT_LOAD, 8'($urandom), 8'(p)), burst);
    send_item(make_item(rc4_pkg::ACT_SCHED, 8'($urandom), 8'($urandom)), burst);
    done = 0;
    while (done < n_items) begin
      roll = $urandom_range(99, 0);
      if (roll < 70) begin
        send_item(make_item(rc4_pkg::ACT_CRYPT, 8'($urandom), 8'($urandom)), burst);
        done++;
      end else if (roll < 84) begin
        // key rewrites, half of them inside the active key
        pos = $urandom_range(1, 0) ? 8'($urandom_range(cur_len - 1, 0)) : 8'($urandom);
        send_item(make_item(rc4_pkg::ACT_LOAD, 8'($urandom), pos), burst);
        done++;
      end else if (roll < 92) begin
        // rekey mid-stream, the indices restart
        send_item(make_item(rc4_pkg::ACT_SCHED, 8'($urandom), 8'($urandom)), burst);
        done++;
      end else begin
        // noise, ignored by the engine and not counted
        send_item(make_item(ACT_SPARE, 8'($urandom), 8'($urandom)), burst);
      end
      // occasionally switch between bursts and gappy traffic mid-phase
      if ($urandom_range(31, 0) == 0) burst = ~burst;
    end
  endtask

  // transfers are sampled at the edge, before any nonblocking update lands;
  // results are checked before the input of the same edge is taken in
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        shadow.check_byte(out_if.data.out_byte);
        results_taken++;
      end
      if (in_if.valid && in_if.ready) shadow.take_item(in_if.data);
      if (cfg_if.valid && cfg_if.ready) shadow.set_key_length(cfg_if.data);
    end
  end

  // receiver: random ready pattern with one long hold-off once traffic flows;
  // the hold-off is counted from the first result left waiting, so the
  // engine is surely stuck in its last crypt step while the sender offers
  initial begin : result_sink
    int unsigned run;
    bit          held;
    held = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && results_taken >= HOLD_AFTER_RESULTS) begin
        out_if.ready <= 1'b0;
        @(posedge clk_i);
        while (!out_if.valid) @(posedge clk_i);
        repeat (HOLD_CYCLES) @(posedge clk_i);
        held = 1'b1;
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(24, 1)) @(posedge clk_i);
      run = pick_gap();
      if (run != 0) begin
        out_if.ready <= 1'b0;
        repeat (run) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    rc4_pkg::cfg_item_t len_plan [8];
    shadow = new();
    key_written = '0;
    cur_len = eff_len(rc4_pkg::KEY_LEN_RESET);

    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: key length from reset, extreme key bytes, a stray write to
    // the top slot, ignored action with all fields high, then extreme data
    for (int p = 0; p < 16; p++)
      send_item(make_item(rc4_pkg::ACT_LOAD, OPENING_KEY[p], 8'(p)), 1'b0);
    send_item(make_item(rc4_pkg::ACT_LOAD, 8'h80, 8'hff), 1'b0);
    send_item(make_item(ACT_SPARE, 8'hff, 8'hff), 1'b0);
    send_item(make_item(rc4_pkg::ACT_SCHED, 8'h00, 8'h00), 1'b0);
    send_item(make_item(rc4_pkg::ACT_CRYPT, 8'h00, 8'h00), 1'b0);
    send_item(make_item(rc4_pkg::ACT_CRYPT, 8'hff, 8'hff), 1'b1);
    send_item(make_item(ACT_SPARE, 8'h00, 8'h00), 1'b1);
    send_item(make_item(rc4_pkg::ACT_CRYPT, 8'h5a, 8'ha5), 1'b1);
    send_item(make_item(rc4_pkg::ACT_CRYPT, 8'ha5, 8'h5a), 1'b0);
    settle();

    // key lengths: minimum, zero, full store, all ones, clamped, tiny,
    // random, just under full
    len_plan = '{9'd1, 9'd0, 9'd256, 9'd511, 9'd300, 9'd2, 9'd3, 9'd255};
    len_plan[6] = 9'($urandom_range(254, 3));
    foreach (len_plan[n]) begin
      write_key_length(len_plan[n]);
      run_phase(PHASE_ITEMS);
      settle();
    end

    if (shadow.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
